// ----- rtl/gbs_pkg.sv -----
// ----------------------------------------------------------------------------
// gbs_pkg
// shared widths, payload types and register codes of the box suppression core
// ----------------------------------------------------------------------------
package gbs_pkg;

   localparam int COORD_W     = 16;
   localparam int SIZE_W      = 15;
   localparam int CLASS_W     = 8;
   localparam int AREA_W      = 2 * SIZE_W;
   localparam int COUNT_W     = 7;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_DATA_W-1:0] IOU_THRESHOLD_RESET = 16'd33423;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [SIZE_W-1:0]         size_type;
   typedef logic [CLASS_W-1:0]        class_type;
   typedef logic [AREA_W-1:0]         area_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [CSR_DATA_W-1:0]     csr_data_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IOU_THRESHOLD  = 1'b0,
      CSR_CLASS_AGNOSTIC = 1'b1
   } csr_index_type;

   // one stored box
   typedef struct packed {
      coord_type left;
      coord_type top;
      size_type  width;
      size_type  height;
      class_type label;
      area_type  area;
   } kept_entry_type;

endpackage

// ----- rtl/gbs_req_if.sv -----
// ----------------------------------------------------------------------------
// gbs_req_if
// request channel: one candidate box per transfer
// ----------------------------------------------------------------------------
interface gbs_req_if;
   import gbs_pkg::*;

   logic      valid;
   logic      ready;
   logic      frame_start;
   coord_type box_left;
   coord_type box_top;
   size_type  box_width;
   size_type  box_height;
   class_type class_label;

   modport source (
      output valid, frame_start, box_left, box_top, box_width, box_height, class_label,
      input  ready
   );

   modport sink (
      input  valid, frame_start, box_left, box_top, box_width, box_height, class_label,
      output ready
   );

endinterface

// ----- rtl/gbs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// gbs_rsp_if
// response channel: verdict on one box per transfer
// ----------------------------------------------------------------------------
interface gbs_rsp_if;
   import gbs_pkg::*;

   logic      valid;
   logic      ready;
   logic      keep;
   logic      overflow;
   count_type kept_count;

   modport source (
      output valid, keep, overflow, kept_count,
      input  ready
   );

   modport sink (
      input  valid, keep, overflow, kept_count,
      output ready
   );

endinterface

// ----- rtl/greedy_box_suppression_core.sv -----
// ----------------------------------------------------------------------------
// greedy_box_suppression_core
// Greedy non-maximum suppression over a stream of score-ordered boxes. Each
// request is checked against every box kept so far in the frame; it is
// suppressed when inter * 65536 > iou_threshold * union for any compared box
// (only same-class boxes unless class_agnostic is set). Survivors are stored
// up to MAX_KEPT; beyond that they are reported with overflow set. The kept
// boxes live in one single-port synchronous memory that is scanned one entry
// per cycle, whatever their class. With n boxes stored ahead of a request
// (frame_start zeroes n), the n entries are read out and pass the read
// register and the compare stages before the response is registered.
// The next request can be taken in the cycle after that; no new box is
// taken before the previous one has its verdict. A new request is
// taken while the previous response still waits in the output register; the
// next response and its store write then wait until that one is taken, and
// the input stalls meanwhile. No clearing pass: the stored count alone marks
// which entries are live.
// ----------------------------------------------------------------------------
module greedy_box_suppression_core #(
   parameter int MAX_KEPT = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   gbs_req_if.sink                  req_bus,
   gbs_rsp_if.source                rsp_bus,
   input  logic                     csr_we,
   input  gbs_pkg::csr_index_type   csr_index,
   input  gbs_pkg::csr_data_type    csr_wdata
);
   import gbs_pkg::*;

   localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CW = $clog2(MAX_KEPT + 1);
   localparam logic [CW-1:0] FULL_TOTAL = CW'(MAX_KEPT);
   localparam int DIFF_W = COORD_W + 1;
   localparam int UNI_W  = AREA_W + 1;
   localparam int PROD_W = CSR_DATA_W + UNI_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   // configuration registers
   csr_data_type iou_thr_ff;
   logic         agnostic_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iou_thr_ff  <= IOU_THRESHOLD_RESET;
         agnostic_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IOU_THRESHOLD:  iou_thr_ff  <= csr_wdata;
            CSR_CLASS_AGNOSTIC: agnostic_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // control state and registered outputs
   state_type state_ff, state_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          sup_ff, sup_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_keep_ff, rsp_keep_in;
   logic          rsp_ovf_ff, rsp_ovf_in;
   count_type     rsp_count_ff, rsp_count_in;
   coord_type     box_left_ff, box_left_in;
   coord_type     box_top_ff, box_top_in;
   size_type      box_w_ff, box_w_in;
   size_type      box_h_ff, box_h_in;
   class_type     box_cls_ff, box_cls_in;

   area_type      area_ff;
   logic          issue;
   logic          mem_we;
   logic          pipe_busy;
   logic          hit;
   logic [CW-1:0] total_inc;

   // read pipeline
   kept_entry_type mem [MAX_KEPT];
   kept_entry_type rd_ff;
   kept_entry_type wr_entry;
   logic           rdv_ff;

   logic           s1_v_ff, s1_match_ff;
   size_type       s1_iw_ff, s1_ih_ff;
   area_type       s1_area_ff;

   logic           s2_v_ff, s2_match_ff;
   area_type       s2_inter_ff, s2_area_ff;

   logic           s3_v_ff, s3_match_ff;
   area_type       s3_inter_ff;
   logic [UNI_W-1:0] s3_uni_ff;

   logic signed [DIFF_W-1:0] iw_diff, ih_diff;
   logic [PROD_W-1:0] lhs, prod;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.keep       = rsp_keep_ff;
   assign rsp_bus.overflow   = rsp_ovf_ff;
   assign rsp_bus.kept_count = rsp_count_ff;

   assign pipe_busy = rdv_ff | s1_v_ff | s2_v_ff | s3_v_ff;
   assign total_inc = total_ff + CW'(1);

   // overlap length of [a0, a0+al) and [b0, b0+bl), clipped at zero
   function automatic logic signed [DIFF_W-1:0] overlap_len(
      input coord_type a0, input size_type al,
      input coord_type b0, input size_type bl
   );
      logic signed [DIFF_W-1:0] a_lo, a_hi, b_lo, b_hi, lo, hi;
      a_lo = DIFF_W'(a0);
      b_lo = DIFF_W'(b0);
      a_hi = a_lo + $signed({2'b00, al});
      b_hi = b_lo + $signed({2'b00, bl});
      lo   = (a_lo > b_lo) ? a_lo : b_lo;
      hi   = (a_hi < b_hi) ? a_hi : b_hi;
      return (hi > lo) ? (hi - lo) : '0;
   endfunction

   assign iw_diff = overlap_len(box_left_ff, box_w_ff, rd_ff.left, rd_ff.width);
   assign ih_diff = overlap_len(box_top_ff, box_h_ff, rd_ff.top, rd_ff.height);

   // final compare: inter * 2^16 against threshold * union
   assign lhs  = {1'b0, s3_inter_ff, 16'h0000};
   assign prod = PROD_W'(iou_thr_ff) * PROD_W'(s3_uni_ff);
   assign hit  = s3_v_ff & s3_match_ff & (lhs > prod);

   assign wr_entry = '{left:   box_left_ff,
                       top:    box_top_ff,
                       width:  box_w_ff,
                       height: box_h_ff,
                       label:  box_cls_ff,
                       area:   area_ff};

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      sup_in       = sup_ff | hit;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_keep_in  = rsp_keep_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_count_in = rsp_count_ff;
      box_left_in  = box_left_ff;
      box_top_in   = box_top_ff;
      box_w_in     = box_w_ff;
      box_h_in     = box_h_ff;
      box_cls_in   = box_cls_ff;
      issue        = 1'b0;
      mem_we       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               // latch the request; frame start empties the store
               box_left_in = req_bus.box_left;
               box_top_in  = req_bus.box_top;
               box_w_in    = req_bus.box_width;
               box_h_in    = req_bus.box_height;
               box_cls_in  = req_bus.class_label;
               if (req_bus.frame_start) begin
                  total_in = '0;
               end
               idx_in   = '0;
               sup_in   = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one stored box read per cycle
            if (idx_ff == total_ff) begin
               state_in = ST_DRAIN;
            end else begin
               issue  = 1'b1;
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_DRAIN: begin
            // wait for the last compare and for a free output register
            if (!pipe_busy && (!rsp_valid_ff || rsp_bus.ready)) begin
               rsp_valid_in = 1'b1;
               rsp_keep_in  = 1'b0;
               rsp_ovf_in   = 1'b0;
               rsp_count_in = COUNT_W'(total_ff);
               if (!sup_ff) begin
                  if (total_ff != FULL_TOTAL) begin
                     mem_we       = 1'b1;
                     total_in     = total_inc;
                     rsp_keep_in  = 1'b1;
                     rsp_count_in = COUNT_W'(total_inc);
                  end else begin
                     rsp_ovf_in = 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         idx_ff       <= '0;
         sup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         idx_ff       <= idx_in;
         sup_ff       <= sup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_keep_ff  <= rsp_keep_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_count_ff <= rsp_count_in;
      box_left_ff  <= box_left_in;
      box_top_ff   <= box_top_in;
      box_w_ff     <= box_w_in;
      box_h_ff     <= box_h_in;
      box_cls_ff   <= box_cls_in;
   end

   // area of the current box, registered from the latched width and height
   always_ff @(posedge clock) begin
      area_ff <= box_w_ff * box_h_ff;
   end

   // kept-box memory, single port: the write of a survivor happens in the
   // response cycle, well before the next request reads it
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[total_ff[AW-1:0]] <= wr_entry;
      end else begin
         rd_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   // compare pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff  <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         rdv_ff  <= issue;
         s1_v_ff <= rdv_ff;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   // overlap widths, intersection area, union
   always_ff @(posedge clock) begin
      s1_iw_ff    <= SIZE_W'(iw_diff);
      s1_ih_ff    <= SIZE_W'(ih_diff);
      s1_area_ff  <= rd_ff.area;
      s1_match_ff <= agnostic_ff | (rd_ff.label == box_cls_ff);

      s2_inter_ff <= s1_iw_ff * s1_ih_ff;
      s2_area_ff  <= s1_area_ff;
      s2_match_ff <= s1_match_ff;

      s3_uni_ff   <= UNI_W'(area_ff) + UNI_W'(s2_area_ff) - UNI_W'(s2_inter_ff);
      s3_inter_ff <= s2_inter_ff;
      s3_match_ff <= s2_match_ff;
   end

endmodule

// ----- rtl/gbs_checker.sv -----
// ----------------------------------------------------------------------------
// gbs_checker
// port-level checks on the box suppression core, bound to the core module
// ----------------------------------------------------------------------------
module gbs_checker #(
   parameter int MAX_KEPT = 64
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_keep,
   input logic       rsp_overflow,
   input logic [6:0] rsp_kept_count
);

   localparam logic [6:0] FULL_COUNT = 7'(MAX_KEPT);

   // a stalled response holds its verdict
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_keep) &&
         $stable(rsp_overflow) && $stable(rsp_kept_count))
      else $error("response changed while stalled");

   // a box is never both stored and reported as overflow
   a_keep_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_keep && rsp_overflow))
      else $error("keep and overflow both set");

   // overflow only when the store is full
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_kept_count == FULL_COUNT)
      else $error("overflow with store not full");

   // no response right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind greedy_box_suppression_core gbs_checker #(
   .MAX_KEPT (MAX_KEPT)
) u_gbs_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_keep       (rsp_bus.keep),
   .rsp_overflow   (rsp_bus.overflow),
   .rsp_kept_count (rsp_bus.kept_count)
);
